// ----- design/atcb_pkg.sv -----
// Shared types and constants of the ATA task-file command builder.
// Holds result codes, register indexes, command bytes and the queued job format.
// Has no dependencies; every other design file imports it.
package atcb_pkg;

   localparam logic [1:0] REQ_READ  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_FLUSH = 2'd2;
   localparam logic [1:0] REQ_NONE  = 2'd3;

   localparam logic [1:0] ACT_WRITE     = 2'd0;
   localparam logic [1:0] ACT_WAIT      = 2'd1;
   localparam logic [1:0] ACT_RANGE_ERR = 2'd2;

   localparam logic [2:0] REG_COUNT   = 3'd0;
   localparam logic [2:0] REG_LBA_LO  = 3'd1;
   localparam logic [2:0] REG_LBA_MID = 3'd2;
   localparam logic [2:0] REG_LBA_HI  = 3'd3;
   localparam logic [2:0] REG_DRIVE   = 3'd4;
   localparam logic [2:0] REG_CMD     = 3'd5;

   localparam logic [7:0] CMD_RD28  = 8'h20;
   localparam logic [7:0] CMD_WR28  = 8'h30;
   localparam logic [7:0] CMD_RD48  = 8'h24;
   localparam logic [7:0] CMD_WR48  = 8'h34;
   localparam logic [7:0] CMD_FLUSH = 8'hE7;

   localparam logic [7:0] DRIVE_LBA28 = 8'hE0;
   localparam logic [7:0] DRIVE_LBA48 = 8'h40;

   localparam logic [63:0] LBA28_LIMIT = 64'h0000_0000_0FFF_FFFF;

   localparam logic [1:0] MODE_FLUSH = 2'd0;
   localparam logic [1:0] MODE_LBA28 = 2'd1;
   localparam logic [1:0] MODE_LBA48 = 2'd2;
   localparam logic [1:0] MODE_ERROR = 2'd3;

   localparam int STEP_W = 4;

   typedef struct packed {
      logic [1:0]  mode;
      logic        is_write;
      logic        slave;
      logic [47:0] lba;
      logic [15:0] count;
   } atcb_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } atcb_queue_status_type;

endpackage

// ----- design/atcb_front.sv -----
// Request front end: accepts requests and classifies them into job descriptors.
// Depends on atcb_pkg; pushes into atcb_queue.
module atcb_front import atcb_pkg::*; (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_type,
   input  logic                  req_use_slave,
   input  logic [63:0]           req_block_address,
   input  logic [15:0]           req_sector_total,
   input  atcb_queue_status_type queue_status,
   output logic                  push,
   output atcb_job_type          job
);

   logic fits_lba28;
   logic beyond_lba48;

   assign fits_lba28   = (req_block_address < LBA28_LIMIT) && (req_sector_total != 16'd0)
                         && (req_sector_total <= 16'd256);
   assign beyond_lba48 = (req_block_address[63:48] != 16'd0);

   always_comb begin
      job.is_write = (req_type == REQ_WRITE);
      job.slave    = req_use_slave;
      job.lba      = req_block_address[47:0];
      job.count    = req_sector_total;
      if (req_type == REQ_FLUSH) begin
         job.mode = MODE_FLUSH;
      end else if (fits_lba28) begin
         job.mode = MODE_LBA28;
      end else if (beyond_lba48) begin
         job.mode = MODE_ERROR;
      end else begin
         job.mode = MODE_LBA48;
      end
   end

   // An unused request type is taken and dropped.
   assign req_stall = queue_status.full;
   assign push      = req_valid && !queue_status.full && (req_type != REQ_NONE);

endmodule

// ----- design/atcb_queue.sv -----
// Short job queue between the front end and the sequencer.
// Depends on atcb_pkg for the job descriptor and status types.
module atcb_queue import atcb_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  atcb_job_type          push_job,
   input  logic                  pop,
   output atcb_job_type          head_job,
   output atcb_queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   atcb_job_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_job     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- design/atcb_back.sv -----
// Sequencer: steps through the queued job, emitting one task-file transfer per cycle
// while rsp_stall is low. Depends on atcb_pkg; drives the registered result channel.
module atcb_back import atcb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  atcb_job_type          head_job,
   input  atcb_queue_status_type queue_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_action,
   output logic [2:0]            rsp_register_index,
   output logic [7:0]            rsp_write_value,
   output logic                  rsp_last
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   logic [1:0]        action_ff, action_in;
   logic [2:0]        index_ff, index_in;
   logic [7:0]        value_ff, value_in;
   logic              last_ff, last_in;
   logic              load;
   logic              produce;
   logic [7:0]        slave_bit;
   logic [7:0]        drive28;

   assign load      = !valid_ff || !rsp_stall;
   assign produce   = load && !queue_status.empty;
   assign slave_bit = {3'b000, head_job.slave, 4'b0000};
   assign drive28   = DRIVE_LBA28 | slave_bit | {4'b0000, head_job.lba[27:24]};

   always_comb begin
      action_in = ACT_WRITE;
      index_in  = REG_COUNT;
      value_in  = 8'd0;
      last_in   = 1'b0;
      case (head_job.mode)
         MODE_FLUSH: begin
            case (step_ff)
               4'd0: begin
                  index_in = REG_DRIVE;
                  value_in = DRIVE_LBA28 | slave_bit;
               end
               4'd1: action_in = ACT_WAIT;
               default: begin
                  index_in = REG_CMD;
                  value_in = CMD_FLUSH;
                  last_in  = 1'b1;
               end
            endcase
         end
         MODE_LBA28: begin
            case (step_ff)
               4'd0: begin
                  index_in = REG_DRIVE;
                  value_in = drive28;
               end
               4'd1: action_in = ACT_WAIT;
               4'd2: begin
                  index_in = REG_COUNT;
                  value_in = head_job.count[7:0];
               end
               4'd3: begin
                  index_in = REG_LBA_LO;
                  value_in = head_job.lba[7:0];
               end
               4'd4: begin
                  index_in = REG_LBA_MID;
                  value_in = head_job.lba[15:8];
               end
               4'd5: begin
                  index_in = REG_LBA_HI;
                  value_in = head_job.lba[23:16];
               end
               4'd6: begin
                  index_in = REG_DRIVE;
                  value_in = drive28;
               end
               default: begin
                  index_in = REG_CMD;
                  value_in = head_job.is_write ? CMD_WR28 : CMD_RD28;
                  last_in  = 1'b1;
               end
            endcase
         end
         MODE_LBA48: begin
            case (step_ff)
               4'd0: begin
                  index_in = REG_DRIVE;
                  value_in = DRIVE_LBA48 | slave_bit;
               end
               4'd1: action_in = ACT_WAIT;
               4'd2: begin
                  index_in = REG_COUNT;
                  value_in = head_job.count[15:8];
               end
               4'd3: begin
                  index_in = REG_LBA_LO;
                  value_in = head_job.lba[31:24];
               end
               4'd4: begin
                  index_in = REG_LBA_MID;
                  value_in = head_job.lba[39:32];
               end
               4'd5: begin
                  index_in = REG_LBA_HI;
                  value_in = head_job.lba[47:40];
               end
               4'd6: begin
                  index_in = REG_COUNT;
                  value_in = head_job.count[7:0];
               end
               4'd7: begin
                  index_in = REG_LBA_LO;
                  value_in = head_job.lba[7:0];
               end
               4'd8: begin
                  index_in = REG_LBA_MID;
                  value_in = head_job.lba[15:8];
               end
               4'd9: begin
                  index_in = REG_LBA_HI;
                  value_in = head_job.lba[23:16];
               end
               default: begin
                  index_in = REG_CMD;
                  value_in = head_job.is_write ? CMD_WR48 : CMD_RD48;
                  last_in  = 1'b1;
               end
            endcase
         end
         default: begin
            action_in = ACT_RANGE_ERR;
            last_in   = 1'b1;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      step_in  = step_ff;
      if (load) begin
         valid_in = produce;
      end
      if (produce) begin
         step_in = last_in ? '0 : step_ff + 1'b1;
      end
   end

   assign pop = produce && last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         action_ff <= action_in;
         index_ff  <= index_in;
         value_ff  <= value_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_action         = action_ff;
   assign rsp_register_index = index_ff;
   assign rsp_write_value    = value_ff;
   assign rsp_last           = last_ff;

endmodule

// ----- design/ata_taskfile_command_builder_top.sv -----
// Top level of the ATA task-file command builder.
// Instantiates atcb_front, atcb_queue and atcb_back; depends on atcb_pkg.
//
// Each request on the req_ channel (read, write or flush cache, master or
// slave drive) becomes the ordered list of task-file register writes, with
// a wait marker where the host must let the busy bit clear. Results leave
// on the rsp_ channel, one transfer per cycle, rsp_last on the final one.
// An LBA28 request gives eight transfers, an LBA48 request eleven, a flush
// three, and an address beyond 48 bits a single error transfer. Request
// type 3 is taken and yields nothing.
// The front end classifies a request in the cycle it is taken and puts it
// in a job queue of QUEUE_DEPTH entries; the sequencer loads each transfer
// from the queue head into the result register. It emits one transfer per
// cycle while rsp_stall is low, and a request already queued follows the
// previous one with no idle cycle between their sequences; the request
// rate is set by the sequencer stepping through its step counter.
// req_stall rises only while the queue is full. When rsp_stall is high with
// a valid result, the registered result holds and the sequencer pauses.
// Synchronous reset empties the queue and clears rsp_valid and the step counter.
module ata_taskfile_command_builder_top import atcb_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic        req_use_slave,
   input  logic [63:0] req_block_address,
   input  logic [15:0] req_sector_total,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_action,
   output logic [2:0]  rsp_register_index,
   output logic [7:0]  rsp_write_value,
   output logic        rsp_last
);

   atcb_job_type          push_job;
   atcb_job_type          head_job;
   atcb_queue_status_type queue_status;
   logic                  push;
   logic                  pop;

   atcb_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_use_slave     (req_use_slave),
      .req_block_address (req_block_address),
      .req_sector_total  (req_sector_total),
      .queue_status      (queue_status),
      .push              (push),
      .job               (push_job)
   );

   atcb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (queue_status)
   );

   atcb_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_job           (head_job),
      .queue_status       (queue_status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_action         (rsp_action),
      .rsp_register_index (rsp_register_index),
      .rsp_write_value    (rsp_write_value),
      .rsp_last           (rsp_last)
   );

endmodule

// ----- design/atcb_checker.sv -----
// Port-level checks on the result channel of the command builder.
// Depends on atcb_pkg; bound to ata_taskfile_command_builder_top.
module atcb_checker import atcb_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_action,
   input logic [2:0] rsp_register_index,
   input logic [7:0] rsp_write_value,
   input logic       rsp_last
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_action)
         && $stable(rsp_register_index) && $stable(rsp_write_value) && $stable(rsp_last))
      else $error("Stalled result transfer changed.");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_WAIT |-> rsp_register_index == REG_COUNT
         && rsp_write_value == 8'd0 && !rsp_last)
      else $error("Malformed wait marker.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_RANGE_ERR |-> rsp_last && rsp_write_value == 8'd0)
      else $error("Range error is not a lone final transfer.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && rsp_action == ACT_WRITE |-> rsp_register_index == REG_CMD)
      else $error("Sequence does not end with a command write.");

endmodule

bind ata_taskfile_command_builder_top atcb_checker u_atcb_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_action         (rsp_action),
   .rsp_register_index (rsp_register_index),
   .rsp_write_value    (rsp_write_value),
   .rsp_last           (rsp_last)
);
